// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, clocked on clock and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clock, disabled while in reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never be true
`define ASSERT_NEVER(label, cond, msg) \
   `ASSERT_CLK(label, !(cond), msg)

`endif

// File: hw/rtl/rmj_pkg.sv
// ----------------------------------------------------------------------------
// rmj_pkg
// Shared types and constants of the radar measurement Jacobian.
// ----------------------------------------------------------------------------
`default_nettype none

package rmj_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int CSR_WIDTH  = 16;

   localparam logic [CSR_WIDTH-1:0] MIN_RANGE_SQ_RESET = 16'd7;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] pos_x;
      logic signed [DATA_WIDTH-1:0] pos_y;
      logic signed [DATA_WIDTH-1:0] vel_x;
      logic signed [DATA_WIDTH-1:0] vel_y;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] range_by_px;
      logic signed [DATA_WIDTH-1:0] range_by_py;
      logic signed [DATA_WIDTH-1:0] bearing_by_px;
      logic signed [DATA_WIDTH-1:0] bearing_by_py;
      logic signed [DATA_WIDTH-1:0] rate_by_px;
      logic signed [DATA_WIDTH-1:0] rate_by_py;
      logic signed [DATA_WIDTH-1:0] rate_by_vx;
      logic signed [DATA_WIDTH-1:0] rate_by_vy;
      logic                         near_zero;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/rmj_div.sv
// ----------------------------------------------------------------------------
// rmj_div
// Pipelined restoring divider, one quotient bit per stage. Flags a quotient
// that does not fit in QW bits; a zero divisor gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rmj_div #(
   parameter int NW   = 48,
   parameter int DENW = 32,
   parameter int QW   = 32
) (
   input  wire logic            clock,
   input  wire logic            enable,
   input  wire logic [NW-1:0]   num_in,
   input  wire logic [DENW-1:0] den_in,
   output logic      [QW-1:0]   quo_out,
   output logic                 ovf_out
);

   logic [DENW-1:0] rem_ff  [0:QW];
   logic [DENW-1:0] rem_in  [0:QW];
   logic [QW-1:0]   low_ff  [0:QW];
   logic [QW-1:0]   low_in  [0:QW];
   logic [QW-1:0]   quo_ff  [0:QW];
   logic [QW-1:0]   quo_in  [0:QW];
   logic [DENW-1:0] den_ff  [0:QW];
   logic [DENW-1:0] den_in_s[0:QW];
   logic            ovf_ff  [0:QW];
   logic            ovf_in  [0:QW];
   logic            zero_ff [0:QW];
   logic            zero_in [0:QW];

   always_comb begin
      logic [DENW-1:0] hi;
      logic [DENW:0]   r2;
      logic [DENW:0]   dx;
      hi = DENW'(num_in[NW-1:QW]);
      rem_in[0]   = hi;
      low_in[0]   = num_in[QW-1:0];
      quo_in[0]   = '0;
      den_in_s[0] = den_in;
      zero_in[0]  = (den_in == '0);
      // quotient needs more than QW bits when the high part reaches the divisor
      ovf_in[0]   = (den_in != '0) && (hi >= den_in);
      for (int k = 0; k < QW; k++) begin
         r2 = {rem_ff[k], low_ff[k][QW-1]};
         dx = {1'b0, den_ff[k]};
         if (r2 >= dx) begin
            rem_in[k+1] = DENW'(r2 - dx);
            quo_in[k+1] = {quo_ff[k][QW-2:0], 1'b1};
         end else begin
            rem_in[k+1] = DENW'(r2);
            quo_in[k+1] = {quo_ff[k][QW-2:0], 1'b0};
         end
         low_in[k+1]   = low_ff[k] << 1;
         den_in_s[k+1] = den_ff[k];
         ovf_in[k+1]   = ovf_ff[k];
         zero_in[k+1]  = zero_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k <= QW; k++) begin
            rem_ff[k]  <= rem_in[k];
            low_ff[k]  <= low_in[k];
            quo_ff[k]  <= quo_in[k];
            den_ff[k]  <= den_in_s[k];
            ovf_ff[k]  <= ovf_in[k];
            zero_ff[k] <= zero_in[k];
         end
      end
   end

   assign quo_out = zero_ff[QW] ? '0 : quo_ff[QW];
   assign ovf_out = ovf_ff[QW];

endmodule

`default_nettype wire

// File: hw/rtl/radar_measurement_jacobian.sv
// ----------------------------------------------------------------------------
// radar_measurement_jacobian
// Jacobian of the polar radar measurement for a Cartesian state vector.
// ----------------------------------------------------------------------------
// Takes one state item (px, py, vx, vy, signed fixed point) per cycle unless
// the pipeline is frozen by rsp_stall, and returns the eight nonzero Jacobian
// entries. The square root resolves one root bit per stage, and the dividers
// one quotient bit per stage plus an overflow check. Quotients truncate toward
// zero and saturate. When px^2+py^2 is below min_range_sq (in the input's
// fixed-point scale) all entries are zero and near_zero is set. rsp_stall
// freezes the whole pipeline while a result is waiting.
`default_nettype none

module radar_measurement_jacobian #(
   parameter int FRAC_BITS = rmj_pkg::FRAC_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire rmj_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output rmj_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_wr_en,
   input  wire logic [rmj_pkg::CSR_WIDTH-1:0] csr_wr_data
);

   localparam int DW  = rmj_pkg::DATA_WIDTH;
   localparam int NST = 2 * DW + 7;
   localparam int N0W = DW + FRAC_BITS;
   localparam int N2W = DW + 2 * FRAC_BITS;
   localparam int N4W = 3 * DW + FRAC_BITS;

   typedef struct packed {
      logic [DW-1:0] pm, qm, xm, ym;
      logic          pn, qn, xn, yn;
   } p1_type;

   typedef struct packed {
      logic [2*DW-1:0] pp, qq, t1, t2;
      logic [DW-1:0]   pm, qm;
      logic            pn, qn, t1n, t2n;
   } p2_type;

   typedef struct packed {
      logic [DW-1:0]   pm, qm;
      logic            pn, qn, dn, below;
      logic [2*DW-1:0] s, dm, sh;
      logic [DW:0]     rem;
      logic [DW-1:0]   root;
   } sq_type;

   typedef struct packed {
      logic [2*DW-1:0] s_lo_rw, s_hi_rw, q_dlo, q_dhi, p_dlo, p_dhi;
      logic [DW-1:0]   rw, pm, qm;
      logic [2*DW-1:0] s;
      logic [5:0]      neg;
      logic            below;
   } m1_type;

   typedef struct packed {
      logic [N0W-1:0]  num0, num1;
      logic [N2W-1:0]  num2, num3;
      logic [N4W-1:0]  num4, num5;
      logic [DW-1:0]   rw;
      logic [2*DW-1:0] s;
      logic [3*DW-1:0] den3;
   } m2_type;

   typedef struct packed {
      logic [5:0] neg;
      logic       below;
   } side_type;

   logic [rmj_pkg::CSR_WIDTH-1:0] min_range_sq_ff;
   logic [NST-1:0]  vld_ff;
   logic            pipe_en;
   p1_type          p1_ff, p1_in;
   p2_type          p2_ff, p2_in;
   sq_type          sq_ff [0:DW];
   sq_type          sq_in [0:DW];
   m1_type          m1_ff, m1_in;
   m2_type          m2_ff, m2_in;
   side_type        m2_side_ff, m2_side_in;
   side_type        side_ff [0:DW];
   rmj_pkg::rsp_type rsp_ff, rsp_in;
   logic [DW-1:0]   quo [0:5];
   logic            ovf [0:5];

   function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] v);
      return v[DW-1] ? DW'(-v) : v;
   endfunction

   function automatic logic [DW-1:0] sat(input logic [DW-1:0] q, input logic o,
                                         input logic n);
      logic [DW-1:0] lim;
      logic [DW-1:0] v;
      lim = {1'b1, {(DW-1){1'b0}}};
      if (n) begin
         v = (o || q > lim) ? lim : q;
         return DW'(-v);
      end
      return (o || q > lim - 1'b1) ? lim - 1'b1 : q;
   endfunction

   assign pipe_en   = !(vld_ff[NST-1] && rsp_stall);
   assign req_stall = !pipe_en;
   assign rsp_valid = vld_ff[NST-1];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_sq_ff <= rmj_pkg::MIN_RANGE_SQ_RESET;
      end else if (csr_wr_en) begin
         min_range_sq_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   // split into sign and magnitude
   always_comb begin
      p1_in.pm = mag_of(req_data.pos_x);
      p1_in.qm = mag_of(req_data.pos_y);
      p1_in.xm = mag_of(req_data.vel_x);
      p1_in.ym = mag_of(req_data.vel_y);
      p1_in.pn = req_data.pos_x[DW-1];
      p1_in.qn = req_data.pos_y[DW-1];
      p1_in.xn = req_data.vel_x[DW-1];
      p1_in.yn = req_data.vel_y[DW-1];
   end

   always_comb begin
      p2_in.pp  = p1_ff.pm * p1_ff.pm;
      p2_in.qq  = p1_ff.qm * p1_ff.qm;
      p2_in.t1  = p1_ff.xm * p1_ff.qm;
      p2_in.t2  = p1_ff.ym * p1_ff.pm;
      p2_in.pm  = p1_ff.pm;
      p2_in.qm  = p1_ff.qm;
      p2_in.pn  = p1_ff.pn;
      p2_in.qn  = p1_ff.qn;
      p2_in.t1n = p1_ff.xn ^ p1_ff.qn;
      p2_in.t2n = !(p1_ff.yn ^ p1_ff.pn);
   end

   // c1, threshold, d = vx*py - vy*px as sign and magnitude, then square root
   always_comb begin
      logic [2*DW-1:0] thr;
      logic [DW+2:0]   rem2;
      logic [DW+2:0]   trial;
      thr = (2*DW)'(min_range_sq_ff) << FRAC_BITS;
      sq_in[0]       = '0;
      sq_in[0].pm    = p2_ff.pm;
      sq_in[0].qm    = p2_ff.qm;
      sq_in[0].pn    = p2_ff.pn;
      sq_in[0].qn    = p2_ff.qn;
      sq_in[0].s     = p2_ff.pp + p2_ff.qq;
      sq_in[0].sh    = p2_ff.pp + p2_ff.qq;
      sq_in[0].below = (p2_ff.pp + p2_ff.qq) < thr;
      if (p2_ff.t1n == p2_ff.t2n) begin
         sq_in[0].dm = p2_ff.t1 + p2_ff.t2;
         sq_in[0].dn = p2_ff.t1n;
      end else if (p2_ff.t1 >= p2_ff.t2) begin
         sq_in[0].dm = p2_ff.t1 - p2_ff.t2;
         sq_in[0].dn = p2_ff.t1n;
      end else begin
         sq_in[0].dm = p2_ff.t2 - p2_ff.t1;
         sq_in[0].dn = p2_ff.t2n;
      end
      for (int k = 0; k < DW; k++) begin
         sq_in[k+1] = sq_ff[k];
         rem2  = {sq_ff[k].rem, sq_ff[k].sh[2*DW-1:2*DW-2]};
         trial = (DW+3)'({sq_ff[k].root, 2'b01});
         if (rem2 >= trial) begin
            sq_in[k+1].rem  = (DW+1)'(rem2 - trial);
            sq_in[k+1].root = {sq_ff[k].root[DW-2:0], 1'b1};
         end else begin
            sq_in[k+1].rem  = (DW+1)'(rem2);
            sq_in[k+1].root = {sq_ff[k].root[DW-2:0], 1'b0};
         end
         sq_in[k+1].sh = sq_ff[k].sh << 2;
      end
   end

   // partial products of c3 = c1*c2 and of px*d, py*d
   always_comb begin
      m1_in.s_lo_rw = sq_ff[DW].s[DW-1:0] * sq_ff[DW].root;
      m1_in.s_hi_rw = sq_ff[DW].s[2*DW-1:DW] * sq_ff[DW].root;
      m1_in.q_dlo   = sq_ff[DW].qm * sq_ff[DW].dm[DW-1:0];
      m1_in.q_dhi   = sq_ff[DW].qm * sq_ff[DW].dm[2*DW-1:DW];
      m1_in.p_dlo   = sq_ff[DW].pm * sq_ff[DW].dm[DW-1:0];
      m1_in.p_dhi   = sq_ff[DW].pm * sq_ff[DW].dm[2*DW-1:DW];
      m1_in.rw      = sq_ff[DW].root;
      m1_in.pm      = sq_ff[DW].pm;
      m1_in.qm      = sq_ff[DW].qm;
      m1_in.s       = sq_ff[DW].s;
      m1_in.neg     = {sq_ff[DW].pn ^ !sq_ff[DW].dn, sq_ff[DW].qn ^ sq_ff[DW].dn,
                       sq_ff[DW].pn, !sq_ff[DW].qn, sq_ff[DW].qn, sq_ff[DW].pn};
      m1_in.below   = sq_ff[DW].below;
   end

   always_comb begin
      m2_in.num0 = N0W'(m1_ff.pm) << FRAC_BITS;
      m2_in.num1 = N0W'(m1_ff.qm) << FRAC_BITS;
      m2_in.num2 = N2W'(m1_ff.qm) << (2 * FRAC_BITS);
      m2_in.num3 = N2W'(m1_ff.pm) << (2 * FRAC_BITS);
      m2_in.num4 = ((N4W'(m1_ff.q_dhi) << DW) + N4W'(m1_ff.q_dlo)) << FRAC_BITS;
      m2_in.num5 = ((N4W'(m1_ff.p_dhi) << DW) + N4W'(m1_ff.p_dlo)) << FRAC_BITS;
      m2_in.rw   = m1_ff.rw;
      m2_in.s    = m1_ff.s;
      m2_in.den3 = ((3*DW)'(m1_ff.s_hi_rw) << DW) + (3*DW)'(m1_ff.s_lo_rw);
      m2_side_in.neg   = m1_ff.neg;
      m2_side_in.below = m1_ff.below;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         for (int k = 0; k <= DW; k++) begin
            sq_ff[k] <= sq_in[k];
         end
         m1_ff      <= m1_in;
         m2_ff      <= m2_in;
         m2_side_ff <= m2_side_in;
         side_ff[0] <= m2_side_ff;
         for (int k = 0; k < DW; k++) begin
            side_ff[k+1] <= side_ff[k];
         end
         rsp_ff <= rsp_in;
      end
   end

   rmj_div #(.NW(N0W), .DENW(DW), .QW(DW)) u_div0 (
      .clock(clock), .enable(pipe_en), .num_in(m2_ff.num0), .den_in(m2_ff.rw),
      .quo_out(quo[0]), .ovf_out(ovf[0]));
   rmj_div #(.NW(N0W), .DENW(DW), .QW(DW)) u_div1 (
      .clock(clock), .enable(pipe_en), .num_in(m2_ff.num1), .den_in(m2_ff.rw),
      .quo_out(quo[1]), .ovf_out(ovf[1]));
   rmj_div #(.NW(N2W), .DENW(2*DW), .QW(DW)) u_div2 (
      .clock(clock), .enable(pipe_en), .num_in(m2_ff.num2), .den_in(m2_ff.s),
      .quo_out(quo[2]), .ovf_out(ovf[2]));
   rmj_div #(.NW(N2W), .DENW(2*DW), .QW(DW)) u_div3 (
      .clock(clock), .enable(pipe_en), .num_in(m2_ff.num3), .den_in(m2_ff.s),
      .quo_out(quo[3]), .ovf_out(ovf[3]));
   rmj_div #(.NW(N4W), .DENW(3*DW), .QW(DW)) u_div4 (
      .clock(clock), .enable(pipe_en), .num_in(m2_ff.num4), .den_in(m2_ff.den3),
      .quo_out(quo[4]), .ovf_out(ovf[4]));
   rmj_div #(.NW(N4W), .DENW(3*DW), .QW(DW)) u_div5 (
      .clock(clock), .enable(pipe_en), .num_in(m2_ff.num5), .den_in(m2_ff.den3),
      .quo_out(quo[5]), .ovf_out(ovf[5]));

   always_comb begin
      logic [DW-1:0] e0, e1;
      e0 = sat(quo[0], ovf[0], side_ff[DW].neg[0]);
      e1 = sat(quo[1], ovf[1], side_ff[DW].neg[1]);
      rsp_in.range_by_px   = e0;
      rsp_in.range_by_py   = e1;
      rsp_in.bearing_by_px = sat(quo[2], ovf[2], side_ff[DW].neg[2]);
      rsp_in.bearing_by_py = sat(quo[3], ovf[3], side_ff[DW].neg[3]);
      rsp_in.rate_by_px    = sat(quo[4], ovf[4], side_ff[DW].neg[4]);
      rsp_in.rate_by_py    = sat(quo[5], ovf[5], side_ff[DW].neg[5]);
      rsp_in.rate_by_vx    = e0;
      rsp_in.rate_by_vy    = e1;
      rsp_in.near_zero     = side_ff[DW].below;
      if (side_ff[DW].below) begin
         rsp_in = '0;
         rsp_in.near_zero = 1'b1;
      end
   end

`include "assert_macros.svh"

   `ASSERT_CLK(a_near_zero_clear, rsp_valid && rsp_data.near_zero |-> rsp_data.range_by_px == '0 && rsp_data.bearing_by_px == '0 && rsp_data.rate_by_px == '0 && rsp_data.rate_by_py == '0, "near_zero item with nonzero entry")
   `ASSERT_CLK(a_row2_copy, rsp_valid |-> rsp_data.rate_by_vx == rsp_data.range_by_px && rsp_data.rate_by_vy == rsp_data.range_by_py, "range rate row does not repeat range row")
   `ASSERT_CLK(a_hold_valid, !pipe_en |=> $stable(vld_ff), "pipeline moved while stalled")
   `ASSERT_NEVER(a_stall_no_out, req_stall && !rsp_valid, "input stalled with no result waiting")

endmodule

`default_nettype wire

// File: bench/radar_measurement_jacobian_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radar_measurement_jacobian_test
// Self-checking bench for the radar measurement Jacobian.
// ----------------------------------------------------------------------------
// A short table of directed state items (zero, unit and extreme positions,
// threshold edges, saturating quotients) is followed by phases of random
// items under several min_range_sq settings. Accepted items not typed in run
// through the wide-integer Jacobian model. Each result item is checked in order,
// field by field. Both channels idle in random bursts, except in the last phase.

module radar_measurement_jacobian_test;

   localparam int DRAIN_CYCLES = 2 * rmj_pkg::DATA_WIDTH + 20;
   localparam int QUIET_LIMIT  = 2000;

   typedef logic [127:0] wide_type;

   typedef struct {
      logic [rmj_pkg::CSR_WIDTH-1:0] thresh;
      rmj_pkg::req_type              state;
      bit                            typed;
      rmj_pkg::rsp_type              result;
   } vector_row_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   rmj_pkg::req_type              req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   rmj_pkg::rsp_type              rsp_data;
   logic                          csr_wr_en = 1'b0;
   logic [rmj_pkg::CSR_WIDTH-1:0] csr_wr_data = '0;

   rmj_pkg::rsp_type              jacobian_q[$];
   vector_row_type                vectors[$];
   logic [rmj_pkg::CSR_WIDTH-1:0] thresh_now = rmj_pkg::MIN_RANGE_SQ_RESET;
   int                            err_count = 0;
   int                            quiet = 0;
   int                            gap_odds = 0;
   int                            stall_odds = 0;
   int                            stall_left = 0;

   radar_measurement_jacobian dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---- model of the Jacobian ----
   function automatic logic [31:0] magnitude(logic [31:0] v);
      return v[31] ? -v : v;
   endfunction

   function automatic wide_type quot(wide_type n, wide_type d);
      return (d == 0) ? '0 : n / d;
   endfunction

   function automatic logic [31:0] saturate(wide_type m, bit neg);
      if (neg) begin
         if (m > (wide_type'(1) << 31)) m = wide_type'(1) << 31;
         return -m[31:0];
      end
      if (m > (wide_type'(1) << 31) - 1) return 32'h7fff_ffff;
      return m[31:0];
   endfunction

   function automatic wide_type int_sqrt(wide_type s);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (wide_type'(c) * wide_type'(c) <= s) r = c;
      end
      return wide_type'(r);
   endfunction

   function automatic rmj_pkg::rsp_type jacobian(rmj_pkg::req_type st,
                                                 logic [rmj_pkg::CSR_WIDTH-1:0] thr);
      rmj_pkg::rsp_type o;
      bit       pn, qn, xn, yn, t1n, t2n, dn;
      wide_type pm, qm, xm, ym, s, rw, t1, t2, dm, den3;
      o  = '0;
      pn = st.pos_x[31]; qn = st.pos_y[31]; xn = st.vel_x[31]; yn = st.vel_y[31];
      pm = wide_type'(magnitude(st.pos_x));
      qm = wide_type'(magnitude(st.pos_y));
      xm = wide_type'(magnitude(st.vel_x));
      ym = wide_type'(magnitude(st.vel_y));
      s  = pm * pm + qm * qm;
      if (s < (wide_type'(thr) << rmj_pkg::FRAC_BITS)) begin
         o.near_zero = 1'b1;
         return o;
      end
      rw = int_sqrt(s);
      o.range_by_px   = saturate(quot(pm << rmj_pkg::FRAC_BITS, rw), pn);
      o.range_by_py   = saturate(quot(qm << rmj_pkg::FRAC_BITS, rw), qn);
      o.bearing_by_px = saturate(quot(qm << (2 * rmj_pkg::FRAC_BITS), s), !qn);
      o.bearing_by_py = saturate(quot(pm << (2 * rmj_pkg::FRAC_BITS), s), pn);
      // d = vx*py - vy*px kept as sign and magnitude
      t1 = xm * qm; t1n = xn ^ qn;
      t2 = ym * pm; t2n = !(yn ^ pn);
      if (t1n == t2n) begin
         dm = t1 + t2; dn = t1n;
      end else if (t1 >= t2) begin
         dm = t1 - t2; dn = t1n;
      end else begin
         dm = t2 - t1; dn = t2n;
      end
      den3 = s * rw;
      o.rate_by_px = saturate(quot((qm * dm) << rmj_pkg::FRAC_BITS, den3), qn ^ dn);
      o.rate_by_py = saturate(quot((pm * dm) << rmj_pkg::FRAC_BITS, den3), pn ^ !dn);
      o.rate_by_vx = o.range_by_px;
      o.rate_by_vy = o.range_by_py;
      return o;
   endfunction

   // ---- result checking and watchdog ----
   always @(posedge clock) begin
      rmj_pkg::rsp_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (jacobian_q.size() == 0) begin
               $error("result item with nothing expected");
               err_count++;
            end else begin
               want = jacobian_q.pop_front();
               if (rsp_data.range_by_px !== want.range_by_px) begin
                  $error("range_by_px exp %h got %h", want.range_by_px, rsp_data.range_by_px);
                  err_count++;
               end
               if (rsp_data.range_by_py !== want.range_by_py) begin
                  $error("range_by_py exp %h got %h", want.range_by_py, rsp_data.range_by_py);
                  err_count++;
               end
               if (rsp_data.bearing_by_px !== want.bearing_by_px) begin
                  $error("bearing_by_px exp %h got %h", want.bearing_by_px,
                         rsp_data.bearing_by_px);
                  err_count++;
               end
               if (rsp_data.bearing_by_py !== want.bearing_by_py) begin
                  $error("bearing_by_py exp %h got %h", want.bearing_by_py,
                         rsp_data.bearing_by_py);
                  err_count++;
               end
               if (rsp_data.rate_by_px !== want.rate_by_px) begin
                  $error("rate_by_px exp %h got %h", want.rate_by_px, rsp_data.rate_by_px);
                  err_count++;
               end
               if (rsp_data.rate_by_py !== want.rate_by_py) begin
                  $error("rate_by_py exp %h got %h", want.rate_by_py, rsp_data.rate_by_py);
                  err_count++;
               end
               if (rsp_data.rate_by_vx !== want.rate_by_vx) begin
                  $error("rate_by_vx exp %h got %h", want.rate_by_vx, rsp_data.rate_by_vx);
                  err_count++;
               end
               if (rsp_data.rate_by_vy !== want.rate_by_vy) begin
                  $error("rate_by_vy exp %h got %h", want.rate_by_vy, rsp_data.rate_by_vy);
                  err_count++;
               end
               if (rsp_data.near_zero !== want.near_zero) begin
                  $error("near_zero exp %b got %b", want.near_zero, rsp_data.near_zero);
                  err_count++;
               end
            end
         end
      end
   end

   // result-side stall bursts; a new burst starts only after rsp_stall has dropped
   always @(posedge clock) begin
      if (stall_left == 0 && !rsp_stall && stall_odds != 0 &&
          $urandom_range(0, stall_odds) == 0)
         stall_left = $urandom_range(1, 11);
      if (reset || stall_odds == 0) stall_left = 0;
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
   end

   // ---- stimulus ----
   task automatic send_state(rmj_pkg::req_type st, bit typed, rmj_pkg::rsp_type result);
      if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= st;
      do @(posedge clock); while (req_stall);
      jacobian_q.push_back(typed ? result : jacobian(st, thresh_now));
   endtask

   task automatic set_thresh(logic [rmj_pkg::CSR_WIDTH-1:0] v);
      req_valid <= 1'b0;
      while (jacobian_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      thresh_now = v;
   endtask

   task automatic add_row(logic [rmj_pkg::CSR_WIDTH-1:0] thr, logic [31:0] px,
                          logic [31:0] py, logic [31:0] vx, logic [31:0] vy,
                          bit typed, rmj_pkg::rsp_type result);
      vector_row_type row;
      row.thresh = thr;
      row.state  = '{px, py, vx, vy};
      row.typed  = typed;
      row.result = result;
      vectors.push_back(row);
   endtask

   function automatic logic [31:0] random_field();
      case ($urandom_range(0, 4))
         0:       return $urandom;
         1:       return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
         2:       return 32'($urandom_range(0, 8)) - 32'd4;
         3: begin
            case ($urandom_range(0, 3))
               0:       return 32'h8000_0000;
               1:       return 32'h7fff_ffff;
               2:       return 32'hffff_ffff;
               default: return 32'h0;
            endcase
         end
         default: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
      endcase
   endfunction

   initial begin
      rmj_pkg::rsp_type none;
      rmj_pkg::req_type st;
      logic [rmj_pkg::CSR_WIDTH-1:0] thr;
      logic [31:0] px;
      none = '0;

      // below threshold and exact / saturating cases are typed in
      add_row(16'd7, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 1'b1});
      add_row(16'd7, 1, 2, 32'h7fff_ffff, 32'h8000_0000, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 1'b1});
      add_row(16'd7, 32'h0001_0000, 0, 0, 0, 1,
              '{32'h10000, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 1'b0});
      add_row(16'd7, 32'hffff_0000, 0, 0, 0, 1,
              '{32'hffff_0000, 0, 0, 32'hffff_0000, 0, 0, 32'hffff_0000, 0, 1'b0});
      add_row(16'd7, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0, none);
      add_row(16'd7, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, none);
      add_row(16'd7, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, none);
      add_row(16'd7, 32'h0003_0000, 32'hfffc_0000, 32'h0001_8000, 32'hffff_0000, 0, none);
      add_row(16'd7, 32'h0000_0100, 32'h0000_0300, 32'h7fff_ffff, 32'h7fff_ffff, 0, none);
      // threshold edge: 512^2 equals 4 << 16
      add_row(16'd4, 512, 0, 0, 0, 0, none);
      add_row(16'd4, 511, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 1'b1});
      add_row(16'd4, 0, 32'hffff_fe00, 5, 9, 0, none);
      // zero threshold: zero range gives all zero entries, tiny range saturates
      add_row(16'd0, 0, 0, 32'h1234_5678, 32'h8765_4321, 1, none);
      add_row(16'd0, 1, 0, 0, 0, 1,
              '{32'h10000, 0, 0, 32'h7fff_ffff, 0, 0, 32'h10000, 0, 1'b0});
      add_row(16'd0, 32'hffff_ffff, 0, 0, 0, 1,
              '{32'hffff_0000, 0, 0, 32'h8000_0000, 0, 0, 32'hffff_0000, 0, 1'b0});
      add_row(16'd0, 0, 1, 0, 0, 1,
              '{0, 32'h10000, 32'h8000_0000, 0, 0, 0, 0, 32'h10000, 1'b0});
      add_row(16'd0, 1, 1, 32'h7fff_ffff, 32'h8000_0000, 0, none);
      add_row(16'd0, 2, 32'hffff_fffd, 32'h8000_0000, 32'h8000_0000, 0, none);
      add_row(16'hffff, 32'h0001_0000, 0, 0, 0, 0, none);
      add_row(16'hffff, 32'h0000_ffff, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0, 0, 0, 1'b1});
      add_row(16'hffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 0, none);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_odds = 3;
      stall_odds = 4;
      foreach (vectors[i]) begin
         if (vectors[i].thresh != thresh_now) set_thresh(vectors[i].thresh);
         send_state(vectors[i].state, vectors[i].typed, vectors[i].result);
      end

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       thr = 16'd0;
            1:       thr = 16'hffff;
            2:       thr = rmj_pkg::MIN_RANGE_SQ_RESET;
            default: thr = 16'($urandom_range(0, 16'hffff));
         endcase
         set_thresh(thr);
         gap_odds   = (phase == 5) ? 0 : $urandom_range(1, 8);
         stall_odds = (phase == 5) ? 0 : $urandom_range(1, 8);
         for (int n = 0; n < 65; n++) begin
            st = '{random_field(), random_field(), random_field(), random_field()};
            // keep some items near the threshold ring
            if ($urandom_range(0, 5) == 0) begin
               px = 32'($urandom_range(0, 1024));
               st.pos_x = $urandom_range(0, 1) ? px : -px;
               st.pos_y = 32'($urandom_range(0, 16)) - 32'd8;
            end
            send_state(st, 0, none);
         end
      end

      req_valid <= 1'b0;
      while (jacobian_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/rmj_pkg.sv
hw/rtl/rmj_div.sv
hw/rtl/radar_measurement_jacobian.sv
bench/radar_measurement_jacobian_test.sv
